// ===== hdl/wedge15_shape_function_eval_assert.svh =====
// Assertion macros used by the RTL.
`ifndef WEDGE15_SHAPE_FUNCTION_EVAL_ASSERT_SVH
`define WEDGE15_SHAPE_FUNCTION_EVAL_ASSERT_SVH
`ifndef ASSERT_OFF
`define W15_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define W15_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define W15_ASSERT_IMP(label, clk, rst, ante, cons)
`define W15_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== hdl/w15_pkg.sv =====
`default_nettype none
package w15_pkg;
  localparam int OUT_W = 20;
  localparam int NODE_W = 4;
  localparam int NODE_COUNT = 15;
  localparam int RS_W = 15;
  localparam int T_W = 16;
  localparam int LANES = 4;
  localparam logic [NODE_W-1:0] LAST_NODE = NODE_W'(NODE_COUNT - 1);

  // rounding shift applied by the second product
  typedef enum logic [1:0] {
    SH_F = 2'd0,  // plain product
    SH_H = 2'd1,  // product then halve
    SH_D = 2'd2   // product then double
  } shift_t;
endpackage
`default_nettype wire

// ===== hdl/wedge15_shape_function_eval.sv =====
// A request passes the front register, the queue, s1, s2, s3 and the output register.
// The node sequencer issues one node per cycle while a request is queued and en is high.
// The output register freezes the back pipeline while node_valid && node_stall.
// A two-entry queue lets the front take the next request during the current run.
// Reset (rst, synchronous) empties the front, queue and pipeline; no result is pending.
`default_nettype none
module wedge15_shape_function_eval #(
  parameter int FRAC_BITS = 14
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              point_valid,
  output logic                                   point_stall,
  input  wire logic [w15_pkg::RS_W-1:0]          coord_r,
  input  wire logic [w15_pkg::RS_W-1:0]          coord_s,
  input  wire logic signed [w15_pkg::T_W-1:0]    coord_t,
  output logic                                   node_valid,
  input  wire logic                              node_stall,
  output logic [w15_pkg::NODE_W-1:0]             node_number,
  output logic signed [w15_pkg::OUT_W-1:0]       shape_value,
  output logic signed [w15_pkg::OUT_W-1:0]       deriv_r,
  output logic signed [w15_pkg::OUT_W-1:0]       deriv_s,
  output logic signed [w15_pkg::OUT_W-1:0]       deriv_t,
  output logic                                   last_node
);
  // operand width: room for 16 * one plus sign over the wider of t and one
  localparam int MAXB = (FRAC_BITS > 16) ? FRAC_BITS : 16;
  localparam int OP_W = MAXB + 6;
  localparam int QW   = 7 * OP_W;

  logic          push;
  logic          full;
  logic [QW-1:0] wr_data;
  logic          avail;
  logic          pop;
  logic [QW-1:0] rd_data;

  // front: register the point, form L, a, b and q
  w15_front #(.FRAC_BITS(FRAC_BITS), .OP_W(OP_W)) u_front (
    .clk, .rst, .point_valid, .point_stall, .coord_r, .coord_s, .coord_t,
    .push, .full, .wr_data
  );

  // decouples the front from the per-node run
  w15_queue #(.W(QW)) u_queue (
    .clk, .rst, .push, .full, .wr_data, .avail, .pop, .rd_data
  );

  // back: node sequencer, two product stages, saturation, output register
  w15_back #(.FRAC_BITS(FRAC_BITS), .OP_W(OP_W)) u_back (
    .clk, .rst, .avail, .pop, .rd_data, .node_valid, .node_stall,
    .node_number, .shape_value, .deriv_r, .deriv_s, .deriv_t, .last_node
  );
endmodule
`default_nettype wire

// ===== hdl/w15_queue.sv =====
`default_nettype none
module w15_queue #(
  parameter int W = 8
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  output logic              full,
  input  wire logic [W-1:0] wr_data,
  output logic              avail,
  input  wire logic         pop,
  output logic [W-1:0]      rd_data
);
  logic [W-1:0] entry [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;
  logic         do_push;
  logic         do_pop;

  assign full    = (count == 2'd2);
  assign avail   = (count != 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && avail;
  assign rd_data = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end
endmodule
`default_nettype wire

// ===== hdl/w15_front.sv =====
`default_nettype none
module w15_front #(
  parameter int FRAC_BITS = 14,
  parameter int OP_W = 22
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          point_valid,
  output logic                               point_stall,
  input  wire logic [w15_pkg::RS_W-1:0]      coord_r,
  input  wire logic [w15_pkg::RS_W-1:0]      coord_s,
  input  wire logic signed [w15_pkg::T_W-1:0] coord_t,
  output logic                               push,
  input  wire logic                          full,
  output logic [7*OP_W-1:0]                  wr_data
);
  localparam int P1_W = 2 * OP_W;
  localparam logic signed [OP_W-1:0] ONE = {{(OP_W-1){1'b0}}, 1'b1} << FRAC_BITS;
  localparam logic signed [P1_W-1:0] HALF = {{(P1_W-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);

  logic                              fv;
  logic [w15_pkg::RS_W-1:0]          pr;
  logic [w15_pkg::RS_W-1:0]          ps;
  logic signed [w15_pkg::T_W-1:0]    pt;
  logic signed [OP_W-1:0]            rx, sx, tx, lx, ax, bx, qx;
  logic signed [P1_W-1:0]            ab;
  logic signed [P1_W-1:0]            abr;

  assign point_stall = fv && full;
  assign push        = fv;

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (!point_stall) begin
      fv <= point_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!point_stall && point_valid) begin
      pr <= coord_r;
      ps <= coord_s;
      pt <= coord_t;
    end
  end

  // L = 1 - r - s, a = 1 - t, b = 1 + t, q = a*b rounded
  always_comb begin
    rx  = signed'({{(OP_W-w15_pkg::RS_W){1'b0}}, pr});
    sx  = signed'({{(OP_W-w15_pkg::RS_W){1'b0}}, ps});
    tx  = {{(OP_W-w15_pkg::T_W){pt[w15_pkg::T_W-1]}}, pt};
    lx  = ONE - rx - sx;
    ax  = ONE - tx;
    bx  = ONE + tx;
    ab  = P1_W'(ax) * P1_W'(bx);
    abr = (ab + HALF) >>> FRAC_BITS;
    qx  = abr[OP_W-1:0];
  end

  assign wr_data = {rx, sx, tx, lx, ax, bx, qx};
endmodule
`default_nettype wire

// ===== hdl/w15_back.sv =====
`default_nettype none
`include "wedge15_shape_function_eval_assert.svh"
module w15_back #(
  parameter int FRAC_BITS = 14,
  parameter int OP_W = 22
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            avail,
  output logic                                 pop,
  input  wire logic [7*OP_W-1:0]               rd_data,
  output logic                                 node_valid,
  input  wire logic                            node_stall,
  output logic [w15_pkg::NODE_W-1:0]           node_number,
  output logic signed [w15_pkg::OUT_W-1:0]     shape_value,
  output logic signed [w15_pkg::OUT_W-1:0]     deriv_r,
  output logic signed [w15_pkg::OUT_W-1:0]     deriv_s,
  output logic signed [w15_pkg::OUT_W-1:0]     deriv_t,
  output logic                                 last_node
);
  localparam int P1_W = 2 * OP_W;
  localparam int M_W  = P1_W - FRAC_BITS;
  localparam int P2_W = M_W + OP_W;
  localparam int N_W  = P2_W + 1;
  localparam int OW   = w15_pkg::OUT_W;
  localparam logic signed [OP_W-1:0] ONE = {{(OP_W-1){1'b0}}, 1'b1} << FRAC_BITS;
  localparam logic signed [P1_W-1:0] HALF1 = {{(P1_W-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);
  localparam logic signed [P2_W-1:0] HALF_F = {{(P2_W-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);
  localparam logic signed [P2_W-1:0] HALF_H = {{(P2_W-1){1'b0}}, 1'b1} << FRAC_BITS;
  localparam logic signed [P2_W-1:0] HALF_D = {{(P2_W-1){1'b0}}, 1'b1} << (FRAC_BITS - 2);

  typedef struct packed {
    logic signed [OP_W-1:0] x;
    logic signed [OP_W-1:0] y;
    logic signed [OP_W-1:0] z;
    w15_pkg::shift_t        k;
    logic                   neg;
  } lane_t;

  function automatic lane_t op(input logic signed [OP_W-1:0] x,
                               input logic signed [OP_W-1:0] y,
                               input logic signed [OP_W-1:0] z,
                               input w15_pkg::shift_t k,
                               input logic neg);
    lane_t o;
    o.x = x;
    o.y = y;
    o.z = z;
    o.k = k;
    o.neg = neg;
    return o;
  endfunction

  logic                          en;
  logic                          issue;
  logic [w15_pkg::NODE_W-1:0]    cnt;
  logic signed [OP_W-1:0]        vr, vs, vt, vl, va, vb, vq;
  logic signed [OP_W-1:0]        zero, two, l2, r2, s2x, t2, l4, r4, s4;
  lane_t                         sel [w15_pkg::LANES];

  lane_t                         s1_op [w15_pkg::LANES];
  logic                          s1_valid;
  logic [w15_pkg::NODE_W-1:0]    s1_node;

  logic signed [P1_W-1:0]        p1 [w15_pkg::LANES];
  logic signed [P1_W-1:0]        p1r [w15_pkg::LANES];
  logic signed [M_W-1:0]         s2_m [w15_pkg::LANES];
  logic signed [OP_W-1:0]        s2_z [w15_pkg::LANES];
  w15_pkg::shift_t               s2_k [w15_pkg::LANES];
  logic                          s2_neg [w15_pkg::LANES];
  logic                          s2_valid;
  logic [w15_pkg::NODE_W-1:0]    s2_node;

  logic signed [P2_W-1:0]        p2 [w15_pkg::LANES];
  logic signed [P2_W-1:0]        p2r [w15_pkg::LANES];
  logic signed [P2_W-1:0]        s3_v [w15_pkg::LANES];
  logic                          s3_neg [w15_pkg::LANES];
  logic                          s3_valid;
  logic [w15_pkg::NODE_W-1:0]    s3_node;

  logic signed [N_W-1:0]         nv [w15_pkg::LANES];
  logic signed [OW-1:0]          sat [w15_pkg::LANES];

  assign en    = !(node_valid && node_stall);
  assign issue = avail && en;
  assign pop   = issue && (cnt == w15_pkg::LAST_NODE);

  always_comb begin
    vr = rd_data[7*OP_W-1 -: OP_W];
    vs = rd_data[6*OP_W-1 -: OP_W];
    vt = rd_data[5*OP_W-1 -: OP_W];
    vl = rd_data[4*OP_W-1 -: OP_W];
    va = rd_data[3*OP_W-1 -: OP_W];
    vb = rd_data[2*OP_W-1 -: OP_W];
    vq = rd_data[OP_W-1:0];
  end

  always_comb begin
    zero = '0;
    two  = ONE <<< 1;
    l2   = vl <<< 1;
    r2   = vr <<< 1;
    s2x  = vs <<< 1;
    t2   = vt <<< 1;
    l4   = vl <<< 2;
    r4   = vr <<< 2;
    s4   = vs <<< 2;
    for (int i = 0; i < w15_pkg::LANES; i++) begin
      sel[i] = op(zero, ONE, ONE, w15_pkg::SH_F, 1'b0);
    end
    // lanes: 0 value, 1 d/dr, 2 d/ds, 3 d/dt
    case (cnt)
      4'd0: begin
        sel[0] = op(vl, va, l2 - vt - two, w15_pkg::SH_H, 1'b0);
        sel[1] = op(va, ONE, two - l4 + vt, w15_pkg::SH_H, 1'b0);
        sel[2] = sel[1];
        sel[3] = op(vl, ONE, ONE - l2 + t2, w15_pkg::SH_H, 1'b0);
      end
      4'd1: begin
        sel[0] = op(vr, va, r2 - vt - two, w15_pkg::SH_H, 1'b0);
        sel[1] = op(va, ONE, r4 - vt - two, w15_pkg::SH_H, 1'b0);
        sel[3] = op(vr, ONE, ONE - r2 + t2, w15_pkg::SH_H, 1'b0);
      end
      4'd2: begin
        sel[0] = op(vs, va, s2x - vt - two, w15_pkg::SH_H, 1'b0);
        sel[2] = op(va, ONE, s4 - vt - two, w15_pkg::SH_H, 1'b0);
        sel[3] = op(vs, ONE, ONE - s2x + t2, w15_pkg::SH_H, 1'b0);
      end
      4'd3: begin
        sel[0] = op(vl, vb, l2 + vt - two, w15_pkg::SH_H, 1'b0);
        sel[1] = op(vb, ONE, two - l4 - vt, w15_pkg::SH_H, 1'b0);
        sel[2] = sel[1];
        sel[3] = op(vl, ONE, l2 + t2 - ONE, w15_pkg::SH_H, 1'b0);
      end
      4'd4: begin
        sel[0] = op(vr, vb, r2 + vt - two, w15_pkg::SH_H, 1'b0);
        sel[1] = op(vb, ONE, r4 + vt - two, w15_pkg::SH_H, 1'b0);
        sel[3] = op(vr, ONE, r2 + t2 - ONE, w15_pkg::SH_H, 1'b0);
      end
      4'd5: begin
        sel[0] = op(vs, vb, s2x + vt - two, w15_pkg::SH_H, 1'b0);
        sel[2] = op(vb, ONE, s4 + vt - two, w15_pkg::SH_H, 1'b0);
        sel[3] = op(vs, ONE, s2x + t2 - ONE, w15_pkg::SH_H, 1'b0);
      end
      4'd6: begin
        sel[0] = op(vr, vl, va, w15_pkg::SH_D, 1'b0);
        sel[1] = op(va, ONE, vl - vr, w15_pkg::SH_D, 1'b0);
        sel[2] = op(vr, ONE, va, w15_pkg::SH_D, 1'b1);
        sel[3] = op(vr, ONE, vl, w15_pkg::SH_D, 1'b1);
      end
      4'd7: begin
        sel[0] = op(vr, vs, va, w15_pkg::SH_D, 1'b0);
        sel[1] = op(vs, ONE, va, w15_pkg::SH_D, 1'b0);
        sel[2] = op(vr, ONE, va, w15_pkg::SH_D, 1'b0);
        sel[3] = op(vr, ONE, vs, w15_pkg::SH_D, 1'b1);
      end
      4'd8: begin
        sel[0] = op(vs, vl, va, w15_pkg::SH_D, 1'b0);
        sel[1] = op(vs, ONE, va, w15_pkg::SH_D, 1'b1);
        sel[2] = op(va, ONE, vl - vs, w15_pkg::SH_D, 1'b0);
        sel[3] = op(vs, ONE, vl, w15_pkg::SH_D, 1'b1);
      end
      4'd9: begin
        sel[0] = op(vr, vl, vb, w15_pkg::SH_D, 1'b0);
        sel[1] = op(vb, ONE, vl - vr, w15_pkg::SH_D, 1'b0);
        sel[2] = op(vr, ONE, vb, w15_pkg::SH_D, 1'b1);
        sel[3] = op(vr, ONE, vl, w15_pkg::SH_D, 1'b0);
      end
      4'd10: begin
        sel[0] = op(vr, vs, vb, w15_pkg::SH_D, 1'b0);
        sel[1] = op(vs, ONE, vb, w15_pkg::SH_D, 1'b0);
        sel[2] = op(vr, ONE, vb, w15_pkg::SH_D, 1'b0);
        sel[3] = op(vr, ONE, vs, w15_pkg::SH_D, 1'b0);
      end
      4'd11: begin
        sel[0] = op(vs, vl, vb, w15_pkg::SH_D, 1'b0);
        sel[1] = op(vs, ONE, vb, w15_pkg::SH_D, 1'b1);
        sel[2] = op(vb, ONE, vl - vs, w15_pkg::SH_D, 1'b0);
        sel[3] = op(vs, ONE, vl, w15_pkg::SH_D, 1'b0);
      end
      4'd12: begin
        sel[0] = op(vl, ONE, vq, w15_pkg::SH_F, 1'b0);
        sel[1] = op(vq, ONE, ONE, w15_pkg::SH_F, 1'b1);
        sel[2] = sel[1];
        sel[3] = op(vt, ONE, vl, w15_pkg::SH_D, 1'b1);
      end
      4'd13: begin
        sel[0] = op(vr, ONE, vq, w15_pkg::SH_F, 1'b0);
        sel[1] = op(vq, ONE, ONE, w15_pkg::SH_F, 1'b0);
        sel[3] = op(vr, ONE, vt, w15_pkg::SH_D, 1'b1);
      end
      4'd14: begin
        sel[0] = op(vs, ONE, vq, w15_pkg::SH_F, 1'b0);
        sel[2] = op(vq, ONE, ONE, w15_pkg::SH_F, 1'b0);
        sel[3] = op(vs, ONE, vt, w15_pkg::SH_D, 1'b1);
      end
      default: begin
      end
    endcase
  end

  // node sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (issue) begin
      cnt <= (cnt == w15_pkg::LAST_NODE) ? '0 : cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      s2_valid   <= 1'b0;
      s3_valid   <= 1'b0;
      node_valid <= 1'b0;
    end else if (en) begin
      s1_valid   <= issue;
      s2_valid   <= s1_valid;
      s3_valid   <= s2_valid;
      node_valid <= s3_valid;
    end
  end

  always_comb begin
    for (int i = 0; i < w15_pkg::LANES; i++) begin
      p1[i]  = P1_W'(s1_op[i].x) * P1_W'(s1_op[i].y);
      p1r[i] = (p1[i] + HALF1) >>> FRAC_BITS;
      p2[i]  = P2_W'(s2_m[i]) * P2_W'(s2_z[i]);
      case (s2_k[i])
        w15_pkg::SH_H: p2r[i] = (p2[i] + HALF_H) >>> (FRAC_BITS + 1);
        w15_pkg::SH_D: p2r[i] = (p2[i] + HALF_D) >>> (FRAC_BITS - 1);
        default:       p2r[i] = (p2[i] + HALF_F) >>> FRAC_BITS;
      endcase
      nv[i] = s3_neg[i] ? -N_W'(s3_v[i]) : N_W'(s3_v[i]);
      if (nv[i][N_W-1:OW-1] == '0 || nv[i][N_W-1:OW-1] == '1) begin
        sat[i] = nv[i][OW-1:0];
      end else begin
        sat[i] = nv[i][N_W-1] ? {1'b1, {(OW-1){1'b0}}} : {1'b0, {(OW-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_node <= cnt;
      s2_node <= s1_node;
      s3_node <= s2_node;
      for (int i = 0; i < w15_pkg::LANES; i++) begin
        s1_op[i]  <= sel[i];
        s2_m[i]   <= p1r[i][M_W-1:0];
        s2_z[i]   <= s1_op[i].z;
        s2_k[i]   <= s1_op[i].k;
        s2_neg[i] <= s1_op[i].neg;
        s3_v[i]   <= p2r[i];
        s3_neg[i] <= s2_neg[i];
      end
      if (s3_valid) begin
        node_number <= s3_node;
        last_node   <= (s3_node == w15_pkg::LAST_NODE);
        shape_value <= sat[0];
        deriv_r     <= sat[1];
        deriv_s     <= sat[2];
        deriv_t     <= sat[3];
      end
    end
  end

  `W15_ASSERT_IMP(a_cnt_range, clk, rst, 1'b1, cnt <= w15_pkg::LAST_NODE)
  `W15_ASSERT_IMP(a_last_tag, clk, rst, node_valid && last_node, node_number == w15_pkg::LAST_NODE)
  `W15_ASSERT_NXT(a_wrap, clk, rst, pop, cnt == '0)
endmodule
`default_nettype wire
